[hw/rtl/owtsm_pkg.sv]
// Shared types and constants of the offset-windowed mean stack.
package owtsm_pkg;

	localparam int MAX_TRACES_DEF = 256;
	localparam int OFFSET_W       = 20;
	localparam int AMP_W          = 32;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_ENABLE  = 2'd0,
		REG_WINDOW_BOUND_A = 2'd1,
		REG_WINDOW_BOUND_B = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] trace_offset;
		logic signed [AMP_W-1:0]    amplitude;
		logic                       amplitude_defined;
		logic                       last_trace;
	} in_item_t;

	typedef struct packed {
		logic signed [AMP_W-1:0] stacked_mean;
		logic                    mean_defined;
	} out_item_t;

	typedef struct packed {
		logic                       enable;
		logic signed [OFFSET_W-1:0] bound_a;
		logic signed [OFFSET_W-1:0] bound_b;
	} window_cfg_t;

endpackage

[hw/rtl/offset_window_trace_stack_mean.sv]
// Offset-windowed mean stack of one time sample of a gather.
//
// trace channel: one beat per trace of the time sample, carrying offset, Q16.16
// amplitude, defined flag and last flag. Beats are taken one per cycle; a beat is
// summed when defined and, with the window on, its offset lies inside the window
// (bounds in either order, inclusive). At most MAX_TRACES beats are summed.
// stack channel: one beat per time sample, on the last trace: the mean truncated
// toward zero, or mean_defined low with a zero mean when nothing was summed.
// cfg channel: always ready; index 0 window enable, 1 and 2 the window bounds.
// The mean comes from the divider, which resolves one quotient bit a cycle; an
// empty stack skips the division and goes from the queue to the result register.
// Throughput: one trace beat a cycle; the divider takes a new sum only once
// its last mean is taken. Two finished sums wait in a queue; the trace channel
// stalls only when that queue is full. A stalled stack receiver holds the
// divider, then the queue fills, then the trace channel stalls. Reset clears
// registers, sums, counts and the queue.
module offset_window_trace_stack_mean #(
	parameter int MAX_TRACES = owtsm_pkg::MAX_TRACES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   trace_valid,
	output logic                                   trace_ready,
	input  owtsm_pkg::in_item_t                    trace,
	output logic                                   stack_valid,
	input  logic                                   stack_ready,
	output owtsm_pkg::out_item_t                   stack,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [owtsm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [owtsm_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import owtsm_pkg::*;

	localparam int CNT_W = $clog2(MAX_TRACES + 1);
	localparam int SUM_W = AMP_W + $clog2(MAX_TRACES);
	localparam int Q_W   = SUM_W + CNT_W;

	window_cfg_t             window_q;
	logic                    push;
	logic                    push_ready;
	logic signed [SUM_W-1:0] push_sum;
	logic [CNT_W-1:0]        push_count;
	logic                    q_valid;
	logic [Q_W-1:0]          q_data;
	logic                    div_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_ENABLE:  window_q.enable  <= cfg_data[0];
				REG_WINDOW_BOUND_A: window_q.bound_a <= cfg_data;
				REG_WINDOW_BOUND_B: window_q.bound_b <= cfg_data;
				default: ;
			endcase
		end
	end

	owtsm_front #(
		.MAX_TRACES (MAX_TRACES),
		.SUM_W      (SUM_W),
		.CNT_W      (CNT_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.window     (window_q),
		.item_valid (trace_valid),
		.item_ready (trace_ready),
		.item       (trace),
		.push       (push),
		.push_sum   (push_sum),
		.push_count (push_count),
		.push_ready (push_ready)
	);

	owtsm_queue #(
		.W (Q_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  ({push_sum, push_count}),
		.push_ready (push_ready),
		.pop_valid  (q_valid),
		.pop_data   (q_data),
		.pop        (div_ready)
	);

	owtsm_div #(
		.SUM_W (SUM_W),
		.CNT_W (CNT_W)
	) u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_valid),
		.job_ready    (div_ready),
		.job_sum      (q_data[Q_W-1:CNT_W]),
		.job_count    (q_data[CNT_W-1:0]),
		.result_valid (stack_valid),
		.result_ready (stack_ready),
		.result       (stack)
	);

`ifndef SYNTHESIS
	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		stack_valid && !stack.mean_defined |-> stack.stacked_mean == '0)
		else $error("undefined mean carries a nonzero value");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		trace_valid && trace_ready && trace.last_trace |=> q_valid)
		else $error("last trace beat did not reach the queue");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		stack_valid && stack_ready |=> !stack_valid)
		else $error("result shown again after it was taken");
`endif

endmodule

[hw/rtl/owtsm_front.sv]
// Front end: offset window test, running sum and count, hand-off on the last beat.
module owtsm_front #(
	parameter int MAX_TRACES = owtsm_pkg::MAX_TRACES_DEF,
	parameter int SUM_W      = 40,
	parameter int CNT_W      = 9
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  owtsm_pkg::window_cfg_t      window,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  owtsm_pkg::in_item_t         item,
	output logic                        push,
	output logic signed [SUM_W-1:0]     push_sum,
	output logic [CNT_W-1:0]            push_count,
	input  logic                        push_ready
);
	import owtsm_pkg::*;

	logic signed [SUM_W-1:0]    sum_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [SUM_W-1:0]    sum_nx;
	logic [CNT_W-1:0]           count_nx;
	logic signed [OFFSET_W-1:0] lo;
	logic signed [OFFSET_W-1:0] hi;
	logic                       in_window;
	logic                       add;
	logic                       take;

	assign item_ready = push_ready;
	assign take       = item_valid && push_ready;

	always_comb begin
		// order the bounds; either may be the lower one
		if (window.bound_a < window.bound_b) begin
			lo = window.bound_a;
			hi = window.bound_b;
		end else begin
			lo = window.bound_b;
			hi = window.bound_a;
		end
		in_window = !window.enable ||
			((item.trace_offset >= lo) && (item.trace_offset <= hi));
		add = item.amplitude_defined && in_window && (count_q < CNT_W'(MAX_TRACES));
		sum_nx   = add ? (sum_q + SUM_W'(item.amplitude)) : sum_q;
		count_nx = add ? (count_q + CNT_W'(1)) : count_q;
	end

	assign push       = take && item.last_trace;
	assign push_sum   = sum_nx;
	assign push_count = count_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (take) begin
			if (item.last_trace) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_nx;
				count_q <= count_nx;
			end
		end
	end

endmodule

[hw/rtl/owtsm_queue.sv]
// Two-entry queue of finished sums and counts between front and divider.
module owtsm_queue #(
	parameter int W = 49
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	output logic         pop_valid,
	output logic [W-1:0] pop_data,
	input  logic         pop
);
	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   count_q;
	logic         do_push;
	logic         do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = mem_q[rptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= !wptr_q;
			end
			if (do_pop) begin
				rptr_q <= !rptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hw/rtl/owtsm_div.sv]
// Back end: one-bit-per-cycle signed sum by count division and result register.
module owtsm_div #(
	parameter int SUM_W = 40,
	parameter int CNT_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	output logic                    job_ready,
	input  logic signed [SUM_W-1:0] job_sum,
	input  logic [CNT_W-1:0]        job_count,
	output logic                    result_valid,
	input  logic                    result_ready,
	output owtsm_pkg::out_item_t    result
);
	import owtsm_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   div_q;
	logic               neg_q;
	out_item_t          result_q;

	logic [CNT_W:0]     r2;
	logic [CNT_W:0]     r_sub;
	logic               ge;
	logic [SUM_W-1:0]   quo_nx;
	logic [SUM_W-1:0]   quo_signed;
	logic [SUM_W-1:0]   mag;

	assign job_ready    = (state_q == ST_IDLE);
	assign result_valid = (state_q == ST_DONE);
	assign result       = result_q;

	always_comb begin
		r2         = {rem_q, quo_q[SUM_W-1]};
		r_sub      = r2 - {1'b0, div_q};
		ge         = (r2 >= {1'b0, div_q});
		quo_nx     = {quo_q[SUM_W-2:0], ge};
		quo_signed = neg_q ? (-quo_nx) : quo_nx;
		mag        = job_sum[SUM_W-1] ? (-job_sum) : job_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			quo_q    <= '0;
			rem_q    <= '0;
			div_q    <= '0;
			neg_q    <= 1'b0;
			result_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						if (job_count == '0) begin
							result_q.stacked_mean <= '0;
							result_q.mean_defined <= 1'b0;
							state_q               <= ST_DONE;
						end else begin
							quo_q   <= mag;
							rem_q   <= '0;
							div_q   <= job_count;
							neg_q   <= job_sum[SUM_W-1];
							step_q  <= STEP_W'(SUM_W - 1);
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					quo_q  <= quo_nx;
					rem_q  <= ge ? r_sub[CNT_W-1:0] : r2[CNT_W-1:0];
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) begin
						// quotient magnitude fits the output width, drop the top bits
						result_q.stacked_mean <= quo_signed[AMP_W-1:0];
						result_q.mean_defined <= 1'b1;
						state_q               <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (result_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/sv/stack_mean_checker.sv]
// Checker for the offset-windowed mean stack: predicts each mean and compares it.
module stack_mean_checker #(
	parameter int MAX_TRACES = owtsm_pkg::MAX_TRACES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                trace_valid,
	input  logic                                trace_ready,
	input  owtsm_pkg::in_item_t                 trace,
	input  logic                                stack_valid,
	input  logic                                stack_ready,
	input  owtsm_pkg::out_item_t                stack,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [owtsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [owtsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	output int                                  errors,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import owtsm_pkg::*;

	logic                       window_on;
	logic signed [OFFSET_W-1:0] bound_a;
	logic signed [OFFSET_W-1:0] bound_b;
	longint                     sum_acc;
	int                         count_acc;
	out_item_t                  expected_means[$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic void stack_one(in_item_t beat);
		logic signed [OFFSET_W-1:0] lo;
		logic signed [OFFSET_W-1:0] hi;
		logic                       hit;
		out_item_t                  mean;
		lo = ($signed(bound_a) < $signed(bound_b)) ? bound_a : bound_b;
		hi = ($signed(bound_a) < $signed(bound_b)) ? bound_b : bound_a;
		hit = beat.amplitude_defined;
		if (window_on && ($signed(beat.trace_offset) < $signed(lo) ||
				$signed(beat.trace_offset) > $signed(hi)))
			hit = 1'b0;
		// drop samples once the stack is full
		if (hit && count_acc < MAX_TRACES) begin
			sum_acc += longint'($signed(beat.amplitude));
			count_acc++;
		end
		if (beat.last_trace) begin
			mean = '0;
			if (count_acc != 0) begin
				mean.stacked_mean = AMP_W'(sum_acc / longint'(count_acc));
				mean.mean_defined = 1'b1;
			end
			expected_means.push_back(mean);
			sum_acc = 0;
			count_acc = 0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			window_on = 1'b0;
			bound_a = '0;
			bound_b = '0;
			sum_acc = 0;
			count_acc = 0;
			expected_means.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WINDOW_ENABLE:  window_on = cfg_data[0];
					REG_WINDOW_BOUND_A: bound_a = cfg_data[OFFSET_W-1:0];
					REG_WINDOW_BOUND_B: bound_b = cfg_data[OFFSET_W-1:0];
					default: ;
				endcase
			end
			if (stack_valid && stack_ready) begin
				if (expected_means.size() == 0) begin
					$display("%0t: unexpected stack beat, got mean %0d defined %0b",
						$time, $signed(stack.stacked_mean), stack.mean_defined);
					errors++;
				end else begin
					want = expected_means.pop_front();
					if (stack.stacked_mean !== want.stacked_mean ||
							stack.mean_defined !== want.mean_defined) begin
						$display("%0t: stack mismatch, expected mean %0d defined %0b, got mean %0d defined %0b",
							$time, $signed(want.stacked_mean), want.mean_defined,
							$signed(stack.stacked_mean), stack.mean_defined);
						errors++;
					end
				end
			end
			if (trace_valid && trace_ready)
				stack_one(trace);
		end
		pending = expected_means.size();
	end

endmodule

[tb/sv/testbench.sv]
// Top of the mean stack testbench: clock, reset, stimulus and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import owtsm_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_ITEMS  = 60;
	localparam int PHASES       = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  trace_valid = 1'b0;
	logic                  trace_ready;
	in_item_t              trace = '0;
	logic                  stack_valid;
	logic                  stack_ready = 1'b0;
	out_item_t             stack;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int cycles = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int win_lo = 0;
	int win_hi = 0;

	offset_window_trace_stack_mean dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.trace_valid (trace_valid),
		.trace_ready (trace_ready),
		.trace       (trace),
		.stack_valid (stack_valid),
		.stack_ready (stack_ready),
		.stack       (stack),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	stack_mean_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.trace_valid (trace_valid),
		.trace_ready (trace_ready),
		.trace       (trace),
		.stack_valid (stack_valid),
		.stack_ready (stack_ready),
		.stack       (stack),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		stack_ready <= ($urandom_range(0, 99) >= recv_stall);
	end

	function automatic in_item_t trace_beat(int offset, logic [AMP_W-1:0] amp,
			logic defined, logic last);
		in_item_t beat;
		beat.trace_offset = OFFSET_W'(offset);
		beat.amplitude = amp;
		beat.amplitude_defined = defined;
		beat.last_trace = last;
		return beat;
	endfunction

	function automatic in_item_t random_trace(logic last);
		int               offset;
		logic [AMP_W-1:0] amp;
		case ($urandom_range(0, 5))
			0, 1: offset = int'($urandom);
			2: offset = win_lo + int'($urandom_range(0, 2)) - 1;
			3: offset = win_hi + int'($urandom_range(0, 2)) - 1;
			default: offset = win_lo + int'($urandom_range(0, win_hi - win_lo));
		endcase
		case ($urandom_range(0, 7))
			4: amp = 32'h7fff_ffff;
			5: amp = 32'h8000_0000;
			6: amp = AMP_W'(int'($urandom_range(0, 200)) - 100);
			7: amp = '0;
			default: amp = $urandom;
		endcase
		return trace_beat(offset, amp, $urandom_range(0, 99) < 85, last);
	endfunction

	// hold valid and payload until the beat is taken
	task automatic push_trace(in_item_t beat);
		while ($urandom_range(0, 99) < send_idle) begin
			trace_valid <= 1'b0;
			@(posedge clk);
		end
		trace_valid <= 1'b1;
		trace <= beat;
		do @(posedge clk); while (!trace_ready);
	endtask

	task automatic drain();
		trace_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(logic en, int a, int b);
		cfg_valid <= 1'b1;
		cfg_index <= REG_WINDOW_ENABLE;
		cfg_data <= CFG_DATA_W'(en);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_WINDOW_BOUND_A;
		cfg_data <= CFG_DATA_W'(a);
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_WINDOW_BOUND_B;
		cfg_data <= CFG_DATA_W'(b);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		win_lo = (a < b) ? a : b;
		win_hi = (a < b) ? b : a;
	endtask

	task automatic run_gathers(int items, bit force_long);
		int       left;
		int       len;
		bit       full;
		in_item_t beat;
		left = items;
		while (left > 0) begin
			full = force_long;
			force_long = 0;
			if (full)
				len = 260;
			else if ($urandom_range(0, 39) == 0)
				len = $urandom_range(257, 300);
			else
				len = $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				beat = random_trace(i == len - 1);
				if (full)
					beat.amplitude_defined = 1'b1;
				push_trace(beat);
			end
			left -= len;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// window off: extremes, truncation toward zero, empty stacks
		push_trace(trace_beat(0, 32'h7fff_ffff, 1'b1, 1'b1));
		push_trace(trace_beat(0, 32'h8000_0000, 1'b1, 1'b1));
		push_trace(trace_beat(5, 32'd1234, 1'b0, 1'b1));
		push_trace(trace_beat(-524288, -32'sd5, 1'b1, 1'b0));
		push_trace(trace_beat(524287, 32'd2, 1'b1, 1'b1));
		push_trace(trace_beat(1, 32'd5, 1'b1, 1'b0));
		push_trace(trace_beat(2, 32'd2, 1'b1, 1'b1));
		push_trace(trace_beat(3, 32'd100, 1'b0, 1'b0));
		push_trace(trace_beat(4, 32'd200, 1'b0, 1'b1));
		push_trace(trace_beat(0, 32'h7fff_ffff, 1'b1, 1'b0));
		push_trace(trace_beat(0, 32'h7fff_ffff, 1'b1, 1'b0));
		push_trace(trace_beat(0, 32'h7fff_ffff, 1'b1, 1'b1));
		drain();

		// reversed window, edges inclusive, last beat inside and outside
		set_window(1'b1, 10, -10);
		push_trace(trace_beat(-11, 32'd1, 1'b1, 1'b0));
		push_trace(trace_beat(-10, 32'd2, 1'b1, 1'b0));
		push_trace(trace_beat(10, 32'd3, 1'b1, 1'b0));
		push_trace(trace_beat(11, 32'd4, 1'b1, 1'b1));
		push_trace(trace_beat(11, 32'd9, 1'b1, 1'b1));
		push_trace(trace_beat(0, -32'sd9, 1'b1, 1'b1));
		push_trace(trace_beat(10, 32'd1, 1'b0, 1'b1));
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 75; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 75; end
				default: begin send_idle = 26; recv_stall = 26; end
			endcase
			case (phase)
				0: set_window(1'b0, 0, 0);
				1: set_window(1'b1, -1000, 1000);
				2: set_window(1'b1, 5000, -3000);
				3: set_window(1'b1, -524288, 524287);
				4: set_window(1'b1, 524287, -524288);
				5: begin
					win_lo = int'($urandom_range(0, 1048575)) - 524288;
					set_window(1'b1, win_lo, win_lo);
				end
				6: set_window(1'b1, int'($urandom_range(0, 1048575)) - 524288,
					int'($urandom_range(0, 1048575)) - 524288);
				default: set_window(1'b0, int'($urandom_range(0, 1048575)) - 524288,
					int'($urandom_range(0, 1048575)) - 524288);
			endcase
			run_gathers(PHASE_ITEMS, phase == 0);
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/owtsm_pkg.sv
hw/rtl/owtsm_front.sv
hw/rtl/owtsm_queue.sv
hw/rtl/owtsm_div.sv
hw/rtl/offset_window_trace_stack_mean.sv
tb/sv/stack_mean_checker.sv
tb/sv/testbench.sv
